// ===== design/nvcr_pkg.sv =====
// Shared constants and widths for the normalized vote class readout.
package nvcr_pkg;
    localparam int N_CLASSES  = 10;
    localparam int N_NETWORKS = 64;
    localparam int N_NEURONS  = N_CLASSES * N_NETWORKS;

    localparam int ADDR_W  = $clog2(N_NEURONS);
    localparam int CLS_W   = $clog2(N_CLASSES);
    localparam int NET_W   = (N_NETWORKS > 1) ? $clog2(N_NETWORKS) : 1;
    localparam int CNT_W   = 16;
    localparam int TOT_W   = CNT_W + $clog2(N_CLASSES);
    localparam int QUO_W   = 17;
    localparam int SUM_W   = 23;
    localparam int STEP_W  = $clog2(QUO_W + 1);
    localparam int NUSE_W  = 7;
    localparam int PER_W   = 16;
    localparam int CFGI_W  = 4;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_PERIOD   = CFGI_W'(0);
    localparam logic [CFGI_W-1:0] CFG_NETWORKS = CFGI_W'(1);

    // Request codes.
    localparam logic REQ_FIRE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
endpackage

// ===== design/normalized_vote_class_readout_unit.sv =====
// Top level: vote counting, period-end normalization sequencer and class pick.
//
//  Channel  | Direction | Handshake              | Payload
//  input    | in        | i_in_valid/o_in_stall  | i_req_type, i_neuron_index
//  output   | out       | o_out_valid/i_out_stall| o_predicted_class, o_no_votes,
//           |           |                        | o_best_score
//  config   | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// An in-range firing reads its counter, then writes it back with a saturating increment;
// an ignored firing and a plain tick end when accepted. A period-closing tick walks all
// N_NETWORKS groups through the one shared divider: per network a read and sum of each
// class counter, then per class a read, 17-step divide, accumulate and clear for a network
// with votes, or a read and clear otherwise, then a scan of the N_CLASSES sums and an emit.
// After reset the block clears all N_NEURONS (640) counters before it takes an item. A
// pending result waits in an output register; only the next period close waits for it.
module normalized_vote_class_readout_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [9:0]                        i_neuron_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [3:0]                        o_predicted_class,
    output logic                              o_no_votes,
    output logic [22:0]                       o_best_score,
    input  logic                              i_cfg_we,
    input  logic [nvcr_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import nvcr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INC_RD, S_INC_WR, S_SUM_RD, S_SUM_ACC,
        S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_CLR_WR, S_SCAN, S_EMIT
    } t_state;

    t_state              r_state;
    logic [PER_W-1:0]    r_period;
    logic [NUSE_W-1:0]   r_nuse;
    logic [PER_W-1:0]    r_tick;
    logic [CLS_W-1:0]    r_rot;
    logic [SUM_W-1:0]    r_sums [N_CLASSES];
    t_addr               r_addr;
    t_addr               r_base;
    logic [CLS_W-1:0]    r_cls;
    logic [NET_W-1:0]    r_net;
    logic [TOT_W-1:0]    r_total;
    logic [CLS_W-1:0]    r_k;
    logic [CLS_W-1:0]    r_i;
    logic [SUM_W-1:0]    r_best;
    logic [CLS_W-1:0]    r_best_cls;
    logic                r_out_valid;
    logic [3:0]          r_out_cls;
    logic                r_out_none;
    logic [22:0]         r_out_score;

    logic [NUSE_W-1:0]   act;
    logic [ADDR_W:0]     limit;
    logic                in_accept;
    logic                mem_we;
    t_addr               mem_addr;
    t_count              mem_wdata;
    t_count              mem_rdata;
    t_count              inc_val;
    logic [PER_W-1:0]    period_eff;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_quot;
    logic                net_used;

    // Effective configuration.
    always_comb begin
        act        = (r_nuse > NUSE_W'(N_NETWORKS)) ? NUSE_W'(N_NETWORKS) : r_nuse;
        limit      = (ADDR_W + 1)'(act) * (ADDR_W + 1)'(N_CLASSES);
        period_eff = (r_period == '0) ? PER_W'(1) : r_period;
        net_used   = ({1'b0, r_net} < act) && (r_total != '0);
        in_accept  = i_in_valid && (r_state == S_IDLE);
        inc_val    = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
        div_start  = (r_state == S_DIV_GO) && net_used;
    end

    // Counter memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = r_base + t_addr'(r_cls);
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_addr;
            end
            S_IDLE: begin
                mem_addr = i_neuron_index[ADDR_W-1:0];
            end
            S_INC_RD: begin
                mem_addr = r_addr;
            end
            S_INC_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_addr;
                mem_wdata = inc_val;
            end
            S_CLR_WR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    nvcr_vote_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    nvcr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (mem_rdata),
        .i_total (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer, configuration and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_period    <= PER_W'(15);
            r_nuse      <= NUSE_W'(64);
            r_tick      <= '0;
            r_rot       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PERIOD) begin
                    r_period <= i_cfg_data;
                end else if (i_cfg_index == CFG_NETWORKS) begin
                    r_nuse <= i_cfg_data[NUSE_W-1:0];
                end
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == t_addr'(N_NEURONS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_addr <= i_neuron_index[ADDR_W-1:0];
                        if (i_req_type == REQ_FIRE) begin
                            if ({1'b0, i_neuron_index} < 11'(limit)) begin
                                r_state <= S_INC_RD;
                            end
                        end else if ((17'(r_tick) + 17'd1) < 17'(period_eff)) begin
                            r_tick <= r_tick + 1'b1;
                        end else begin
                            r_tick  <= '0;
                            r_base  <= '0;
                            r_cls   <= '0;
                            r_net   <= '0;
                            r_total <= '0;
                            for (int c = 0; c < N_CLASSES; c++) begin
                                r_sums[c] <= '0;
                            end
                            r_state <= S_SUM_RD;
                        end
                    end
                end
                S_INC_RD: begin
                    r_state <= S_INC_WR;
                end
                S_INC_WR: begin
                    r_state <= S_IDLE;
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_total <= r_total + TOT_W'(mem_rdata);
                    if (r_cls == CLS_W'(N_CLASSES - 1)) begin
                        r_cls   <= '0;
                        r_state <= S_DIV_RD;
                    end else begin
                        r_cls   <= r_cls + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_DIV_RD: begin
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= net_used ? S_DIV_WAIT : S_CLR_WR;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_sums[r_cls] <= r_sums[r_cls] + SUM_W'(div_quot);
                        r_state       <= S_CLR_WR;
                    end
                end
                S_CLR_WR: begin
                    if (r_cls == CLS_W'(N_CLASSES - 1)) begin
                        r_cls   <= '0;
                        r_total <= '0;
                        r_base  <= r_base + t_addr'(N_CLASSES);
                        r_net   <= r_net + 1'b1;
                        if (r_net == NET_W'(N_NETWORKS - 1)) begin
                            r_k        <= r_rot;
                            r_i        <= '0;
                            r_best     <= '0;
                            r_best_cls <= '0;
                            r_state    <= S_SCAN;
                        end else begin
                            r_state <= S_SUM_RD;
                        end
                    end else begin
                        r_cls   <= r_cls + 1'b1;
                        r_state <= S_DIV_RD;
                    end
                end
                S_SCAN: begin
                    // First strict maximum from the rotating start wins.
                    if (r_sums[r_k] > r_best) begin
                        r_best     <= r_sums[r_k];
                        r_best_cls <= r_k;
                    end
                    r_k <= (r_k == CLS_W'(N_CLASSES - 1)) ? '0 : r_k + 1'b1;
                    r_i <= r_i + 1'b1;
                    if (r_i == CLS_W'(N_CLASSES - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_none  <= (r_best == '0);
                        r_out_cls   <= (r_best == '0) ? 4'd0 : 4'(r_best_cls);
                        r_out_score <= r_best;
                        r_rot   <= (r_rot == CLS_W'(N_CLASSES - 1)) ? '0 : r_rot + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_predicted_class = r_out_cls;
    assign o_no_votes        = r_out_none;
    assign o_best_score      = r_out_score;
endmodule

// ===== design/nvcr_vote_mem.sv =====
// Vote counter memory: one write port and one registered read port.
module nvcr_vote_mem (
    input  logic             i_clk,
    input  logic             i_we,
    input  nvcr_pkg::t_addr  i_addr,
    input  nvcr_pkg::t_count i_wdata,
    output nvcr_pkg::t_count o_rdata
);
    import nvcr_pkg::*;

    t_count r_mem [N_NEURONS];
    t_count r_rdata;

    // Write and registered read at the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/nvcr_divider.sv =====
// Restoring divider, one quotient bit per cycle while busy: (count * 65536) / total.
module nvcr_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  nvcr_pkg::t_count                    i_count,
    input  logic [nvcr_pkg::TOT_W-1:0]          i_total,
    output logic                                o_done,
    output logic [nvcr_pkg::QUO_W-1:0]          o_quot
);
    import nvcr_pkg::*;

    logic [TOT_W:0]    r_rem;
    logic [TOT_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_quot;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              ge;
    logic [TOT_W:0]    rem_sub;

    // The remainder stays below the divisor, so the shifted value fits.
    always_comb begin
        ge      = (r_rem >= {1'b0, r_div});
        rem_sub = ge ? (r_rem - {1'b0, r_div}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= {(TOT_W + 1 - CNT_W)'(0), i_count};
                r_div  <= i_total;
                r_quot <= '0;
            end else if (r_busy) begin
                r_quot <= {r_quot[QUO_W-2:0], ge};
                r_rem  <= {rem_sub[TOT_W-1:0], 1'b0};
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
